### hw/rtl/cbmf_pkg.sv
package cbmf_pkg;

	// window store depth default and field widths
	localparam int MAX_WINDOW_DEF = 256;
	localparam int SAMPLE_W       = 16;
	localparam int SUM_W          = 24;
	localparam int POS_W          = 16;
	localparam int WL_W           = 9;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 2;

	// queue between front and back, and result queue
	localparam int WORK_DEPTH = 4;
	localparam int WORK_CNT_W = $clog2(WORK_DEPTH + 1);
	localparam int RES_DEPTH  = 4;

	localparam logic [POS_W-1:0] RECORD_LENGTH_RST = 16'd1024;
	localparam logic [WL_W-1:0]  WINDOW_LENGTH_RST = 9'd16;
	localparam logic [POS_W-1:0] PERIOD_COUNT_RST  = 16'd1024;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RECORD_LENGTH = 2'd0,
		REG_WINDOW_LENGTH = 2'd1,
		REG_PERIOD_COUNT  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [POS_W-1:0] record_length;
		logic [WL_W-1:0]  window_length;
		logic [POS_W-1:0] period_count;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_re;
		logic signed [SAMPLE_W-1:0] sample_im;
	} sample_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_re;
		logic signed [SUM_W-1:0] sum_im;
		logic [POS_W-1:0]        delay_bin;
		logic                    period_end;
		logic                    frame_end;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] new_re;
		logic signed [SAMPLE_W-1:0] new_im;
		logic signed [SAMPLE_W-1:0] old_re;
		logic signed [SAMPLE_W-1:0] old_im;
		logic                       clear;
		logic                       drop;
		logic                       emit;
		logic [POS_W-1:0]           delay_bin;
		logic                       period_end;
		logic                       frame_end;
	} work_t;

endpackage

### hw/rtl/cbmf_ram.sv
module cbmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

### hw/rtl/cbmf_fifo.sv
module cbmf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic [CNTW-1:0]  count,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             push_ok, pop_ok;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNTW'(DEPTH));
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("fifo count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo pointers apart while empty");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ok && !push_ok) |=> (count_q == $past(count_q) - 1'b1))
		else $error("fifo pop lost");

endmodule

### hw/rtl/cbmf_front.sv
module cbmf_front #(
	parameter int MAX_WINDOW = cbmf_pkg::MAX_WINDOW_DEF,
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbmf_pkg::cfg_t                      cfg,
	input  logic                                push,
	input  cbmf_pkg::sample_t                   sample,
	output logic                                full,
	input  logic [cbmf_pkg::WORK_CNT_W-1:0]     q_count,
	output logic                                ram_we,
	output logic [AW-1:0]                       ram_waddr,
	output logic [2*cbmf_pkg::SAMPLE_W-1:0]     ram_wdata,
	output logic [AW-1:0]                       ram_raddr,
	input  logic [2*cbmf_pkg::SAMPLE_W-1:0]     ram_rdata,
	output logic                                q_push,
	output cbmf_pkg::work_t                     q_data
);

	localparam int PW  = cbmf_pkg::POS_W;
	localparam int WLW = cbmf_pkg::WL_W;
	localparam int SW  = cbmf_pkg::SAMPLE_W;
	localparam int CW  = (AW + 1 > WLW) ? AW + 1 : WLW;
	localparam int QW  = cbmf_pkg::WORK_CNT_W + 1;

	logic [PW-1:0] pos_q, per_q;
	logic [AW-1:0] wp_q;
	logic          accept;

	logic [CW-1:0] wl_ext, wp_ext, raddr_full;
	logic [PW-1:0] wl16, last_pos, last_per;
	logic          wl_ok, clear, drop, emit, pend, fend;
	logic [PW-1:0] delay_bin;

	logic              valid_s1;
	cbmf_pkg::sample_t sample_s1;
	logic              clear_s1, drop_s1, emit_s1, pend_s1, fend_s1;
	logic [PW-1:0]     delay_s1;

	// reserve a slot for the transaction held in s1
	assign full   = ({1'b0, q_count} + QW'(valid_s1)) >= QW'(cbmf_pkg::WORK_DEPTH);
	assign accept = push && !full;

	assign wl_ext   = CW'(cfg.window_length);
	assign wp_ext   = CW'(wp_q);
	assign wl16     = PW'(cfg.window_length);
	assign wl_ok    = (cfg.window_length != '0) && (wl_ext <= CW'(MAX_WINDOW));
	assign last_pos = cfg.record_length - 1'b1;
	assign last_per = cfg.period_count - 1'b1;

	assign raddr_full = (wp_ext >= wl_ext) ? (wp_ext - wl_ext)
	                                       : (wp_ext + CW'(MAX_WINDOW) - wl_ext);

	always_comb begin
		clear     = (pos_q == '0);
		drop      = wl_ok && (pos_q >= wl16);
		emit      = wl_ok && ((cfg.record_length == '0) || (wl16 <= cfg.record_length))
		            && (({1'b0, pos_q} + 1'b1) >= {1'b0, wl16});
		delay_bin = pos_q + 1'b1 - wl16;
		pend      = (pos_q == last_pos);
		fend      = pend && (per_q == last_per);
	end

	assign ram_we    = accept;
	assign ram_waddr = wp_q;
	assign ram_wdata = {sample.sample_im, sample.sample_re};
	assign ram_raddr = raddr_full[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			per_q    <= '0;
			wp_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
				if (pend) begin
					pos_q <= '0;
					per_q <= fend ? '0 : per_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			clear_s1  <= clear;
			drop_s1   <= drop;
			emit_s1   <= emit;
			delay_s1  <= delay_bin;
			pend_s1   <= pend;
			fend_s1   <= fend;
		end
	end

	assign q_push = valid_s1;
	always_comb begin
		q_data            = '0;
		q_data.new_re     = sample_s1.sample_re;
		q_data.new_im     = sample_s1.sample_im;
		q_data.old_re     = ram_rdata[SW-1:0];
		q_data.old_im     = ram_rdata[2*SW-1:SW];
		q_data.clear      = clear_s1;
		q_data.drop       = drop_s1;
		q_data.emit       = emit_s1;
		q_data.delay_bin  = delay_s1;
		q_data.period_end = pend_s1;
		q_data.frame_end  = fend_s1;
	end

	a_room_for_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (q_count < cbmf_pkg::WORK_CNT_W'(cbmf_pkg::WORK_DEPTH)))
		else $error("work queue overrun from s1");

	a_period_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pend) |=> (pos_q == '0))
		else $error("position did not wrap at period end");

	a_frame_end_is_period_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (!fend_s1 || pend_s1))
		else $error("frame end without period end");

endmodule

### hw/rtl/cbmf_back.sv
module cbmf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cbmf_pkg::work_t   work,
	input  logic              work_empty,
	output logic              work_pop,
	input  logic              res_full,
	output logic              res_push,
	output cbmf_pkg::result_t res_data
);

	localparam int SUMW = cbmf_pkg::SUM_W;
	localparam int SW   = cbmf_pkg::SAMPLE_W;

	logic signed [SUMW-1:0] run_re_q, run_im_q;
	logic signed [SUMW-1:0] base_re, base_im, next_re, next_im;
	logic signed [SUMW-1:0] add_re, add_im, sub_re, sub_im;

	assign work_pop = !work_empty && !res_full;
	assign res_push = work_pop && work.emit;

	always_comb begin
		base_re = work.clear ? '0 : run_re_q;
		base_im = work.clear ? '0 : run_im_q;
		add_re  = {{(SUMW-SW){work.new_re[SW-1]}}, work.new_re};
		add_im  = {{(SUMW-SW){work.new_im[SW-1]}}, work.new_im};
		sub_re  = work.drop ? {{(SUMW-SW){work.old_re[SW-1]}}, work.old_re} : '0;
		sub_im  = work.drop ? {{(SUMW-SW){work.old_im[SW-1]}}, work.old_im} : '0;
		next_re = base_re + add_re - sub_re;
		next_im = base_im + add_im - sub_im;
	end

	always_comb begin
		res_data            = '0;
		res_data.sum_re     = next_re;
		res_data.sum_im     = next_im;
		res_data.delay_bin  = work.delay_bin;
		res_data.period_end = work.period_end;
		res_data.frame_end  = work.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_re_q <= '0;
			run_im_q <= '0;
		end else if (work_pop) begin
			run_re_q <= next_re;
			run_im_q <= next_im;
		end
	end

	a_clear_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(work_pop && work.clear && !work.drop) |=>
		(run_re_q == {{(SUMW-SW){$past(work.new_re[SW-1])}}, $past(work.new_re)}))
		else $error("sum did not restart at period start");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!work_pop |=> ($stable(run_re_q) && $stable(run_im_q)))
		else $error("sum moved without a transaction");

endmodule

### hw/rtl/complex_boxcar_matched_filter_unit.sv
// Complex boxcar range matched filter. Each I/Q sample pushed in is placed in
// its pulse period of record_length samples; from the window_length-th sample
// of the period on, every sample yields one result: the complex sum of
// the last window_length samples, its delay bin, and period/frame end flags
// (a frame is period_count periods). A window_length of zero, above a nonzero
// record_length or above MAX_WINDOW yields no results, but the counters run.
// Throughput is one sample per clock while full is low, set by the
// one-write/one-read window RAM (MAX_WINDOW x 32 bits) and the back-end
// accumulator. A result passes the s1 register, the work queue and the result
// queue to the result port. Write configuration only while the block is idle.
module complex_boxcar_matched_filter_unit #(
	parameter int MAX_WINDOW = cbmf_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample side: push / full
	input  logic                               push,
	output logic                               full,
	input  cbmf_pkg::sample_t                  sample,
	// result side: empty / pop
	output logic                               empty,
	input  logic                               pop,
	output cbmf_pkg::result_t                  result,
	// register write port
	input  logic                               wr_en,
	input  logic [cbmf_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [cbmf_pkg::CFG_DATA_W-1:0]    wr_data
);

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SW    = cbmf_pkg::SAMPLE_W;
	localparam int WORKW = $bits(cbmf_pkg::work_t);
	localparam int RESW  = $bits(cbmf_pkg::result_t);
	localparam int RCW   = $clog2(cbmf_pkg::RES_DEPTH + 1);

	cbmf_pkg::cfg_t cfg_q;

	// Registers. Unlisted indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.record_length <= cbmf_pkg::RECORD_LENGTH_RST;
			cfg_q.window_length <= cbmf_pkg::WINDOW_LENGTH_RST;
			cfg_q.period_count  <= cbmf_pkg::PERIOD_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				cbmf_pkg::REG_RECORD_LENGTH: cfg_q.record_length <= wr_data;
				cbmf_pkg::REG_WINDOW_LENGTH:
					cfg_q.window_length <= wr_data[cbmf_pkg::WL_W-1:0];
				cbmf_pkg::REG_PERIOD_COUNT:  cfg_q.period_count  <= wr_data;
				default: ;
			endcase
		end
	end

	// Window store: written at the rolling position, read wl entries back.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [2*SW-1:0]      ram_wdata, ram_rdata;

	cbmf_ram #(
		.WIDTH (2*SW),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Front end: counters, classification, store access.
	logic                              q_push;
	cbmf_pkg::work_t                   q_wdata, q_rdata;
	logic [WORKW-1:0]                  q_rvec;
	logic [cbmf_pkg::WORK_CNT_W-1:0]   q_count;
	logic                              q_empty, q_full, q_pop;

	cbmf_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.q_count   (q_count),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// Work queue decouples the front end from the accumulator.
	cbmf_fifo #(
		.WIDTH (WORKW),
		.DEPTH (cbmf_pkg::WORK_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rvec),
		.count  (q_count),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign q_rdata = cbmf_pkg::work_t'(q_rvec);

	// Back end: sliding sums.
	logic              res_push, res_full;
	cbmf_pkg::result_t res_wdata;
	logic [RESW-1:0]   res_rvec;
	logic [RCW-1:0]    res_count;

	cbmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (q_rdata),
		.work_empty (q_empty),
		.work_pop   (q_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_wdata)
	);

	// Result queue: the oldest waiting result drives the result port.
	cbmf_fifo #(
		.WIDTH (RESW),
		.DEPTH (cbmf_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (pop),
		.rdata  (res_rvec),
		.count  (res_count),
		.empty  (empty),
		.full   (res_full)
	);

	assign result = cbmf_pkg::result_t'(res_rvec);

	// The front end reserves room, so the work queue never sees a push it drops.
	a_no_work_drop: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("work transaction dropped");

	// The accumulator only pushes results into a queue with room.
	a_no_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count < RCW'(cbmf_pkg::RES_DEPTH)))
		else $error("result transaction dropped");

	// A taken sample shows up at the work queue input in the next cycle.
	a_s1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> q_push)
		else $error("accepted sample lost before work queue");

endmodule
